// File: rtl/olmrs_pkg.sv
// ----------------------------------------------------------------------------
// olmrs_pkg - shared types and constants
// Widths, opcodes and sizes for the ordered list with move and rank select.
// ----------------------------------------------------------------------------
`default_nettype none

package olmrs_pkg;

  localparam int DEPTH  = 1024;
  localparam int RANK_W = $clog2(DEPTH);
  localparam int ID_W   = 11;
  localparam int OP_W   = 3;
  localparam int OFF_W  = 2;

  typedef logic [OP_W-1:0]         opcode_t;
  typedef logic [ID_W-1:0]         id_t;
  typedef logic [RANK_W-1:0]       rank_t;
  typedef logic [RANK_W:0]         count_t;
  typedef logic signed [OFF_W-1:0] offset_t;

  localparam opcode_t OP_APPEND = 3'd0;
  localparam opcode_t OP_TOP    = 3'd1;
  localparam opcode_t OP_BOTTOM = 3'd2;
  localparam opcode_t OP_SHIFT  = 3'd3;
  localparam opcode_t OP_ASK    = 3'd4;
  localparam opcode_t OP_QUERY  = 3'd5;

endpackage

`default_nettype wire

// File: rtl/olmrs_in_if.sv
// ----------------------------------------------------------------------------
// olmrs_in_if - request channel
// Valid/ready channel carrying one list operation.
// ----------------------------------------------------------------------------
`default_nettype none

interface olmrs_in_if;
  import olmrs_pkg::*;

  logic    valid;
  logic    ready;
  opcode_t opcode;
  id_t     target;
  offset_t offset;

  modport source (output valid, output opcode, output target, output offset, input ready);
  modport sink   (input valid, input opcode, input target, input offset, output ready);
endinterface

`default_nettype wire

// File: rtl/olmrs_out_if.sv
// ----------------------------------------------------------------------------
// olmrs_out_if - result channel
// Valid/ready channel carrying one answer.
// ----------------------------------------------------------------------------
`default_nettype none

interface olmrs_out_if;
  import olmrs_pkg::*;

  logic valid;
  logic ready;
  id_t  answer;

  modport source (output valid, output answer, input ready);
  modport sink   (input valid, input answer, output ready);
endinterface

`default_nettype wire

// File: rtl/ordered_list_move_rank_select_top.sv
// ----------------------------------------------------------------------------
// ordered_list_move_rank_select_top - ordered id list, move and rank select
// Keeps a list of distinct ids as a rank->id table and an id->rank table,
// both in single-port-read, single-port-write memories, under a small
// sequencer that walks one entry per cycle for moves.
// ----------------------------------------------------------------------------
//
//  channel   | dir | handshake   | payload
//  ----------+-----+-------------+-------------------------------------
//  in_req    | in  | valid/ready | opcode[2:0], target[10:0], offset[1:0]
//  out_rsp   | out | valid/ready | answer[10:0] (ask and query only)
//
//  Move to top, move to bottom and shift walk the entries between the old
//  and new rank, paced by the rank->id memory read port, one entry per
//  cycle. A move or shift of an absent id changes nothing.
//  Reset clears the fill count and control only; table contents are
//  undefined until written, presence is judged against the fill count.
//  in_req.ready is high only while idle. A waiting answer is held in the
//  output register and does not block the next request; only a second
//  answer waits for it to be taken.
// ----------------------------------------------------------------------------
`default_nettype none

module ordered_list_move_rank_select_top (
  input  wire logic   clk,
  input  wire logic   rst_n,
  olmrs_in_if.sink    in_req,
  olmrs_out_if.source out_rsp
);
  import olmrs_pkg::*;

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;  // waiting for a request
  localparam logic [2:0] S_RDR  = 3'd1;  // id->rank data back, read rank->id
  localparam logic [2:0] S_CHK  = 3'd2;  // presence known, dispatch
  localparam logic [2:0] S_MOVE = 3'd3;  // walk entries one per cycle
  localparam logic [2:0] S_OUT  = 3'd4;  // hand answer to output register

  logic [2:0] state_r, state_nxt;

  // latched request
  opcode_t op_r, op_nxt;
  id_t     tgt_r, tgt_nxt;
  offset_t off_r, off_nxt;

  // lookup results
  rank_t rank_r, rank_nxt;
  logic  rok_r, rok_nxt;

  // move walker
  rank_t cur_r, cur_nxt;
  rank_t end_r, end_nxt;
  logic  up_r, up_nxt;
  logic  pend_r, pend_nxt;
  rank_t pdst_r, pdst_nxt;

  count_t fill_r, fill_nxt;

  // answer path
  id_t  res_r, res_nxt;
  id_t  ans_r, ans_nxt;
  logic oval_r, oval_nxt;

  // memories
  id_t   r2i_mem [DEPTH];
  rank_t i2r_mem [DEPTH];
  id_t   r2i_rd_r;
  rank_t i2r_rd_r;

  logic  r2i_we, i2r_we;
  rank_t r2i_waddr, i2r_waddr, r2i_raddr, i2r_raddr;
  id_t   r2i_wdata;
  rank_t i2r_wdata;

  logic  id_ok, present, app_ok, qry_ok;
  rank_t src;

  assign in_req.ready   = (state_r == S_IDLE);
  assign out_rsp.valid  = oval_r;
  assign out_rsp.answer = ans_r;

  // ---- lookups ----
  assign id_ok   = (tgt_r != '0) && (tgt_r <= ID_W'(DEPTH));
  // an id is present only if its rank is in range and points back to it
  assign present = id_ok && rok_r && (r2i_rd_r == tgt_r);
  assign app_ok  = (fill_r < count_t'(DEPTH)) && id_ok && !present;
  assign qry_ok  = (tgt_r != '0) && (tgt_r <= ID_W'(fill_r));
  assign src     = up_r ? rank_t'(cur_r - 1'b1) : rank_t'(cur_r + 1'b1);

  assign i2r_raddr = rank_t'(in_req.target - 1'b1);

  always_comb begin
    if (state_r == S_RDR) begin
      r2i_raddr = (op_r == OP_QUERY) ? rank_t'(tgt_r - 1'b1) : i2r_rd_r;
    end else begin
      r2i_raddr = src;
    end
  end

  // ---- write port selection ----
  always_comb begin
    r2i_we    = 1'b0;
    i2r_we    = 1'b0;
    r2i_waddr = '0;
    i2r_waddr = '0;
    r2i_wdata = '0;
    i2r_wdata = '0;
    if (pend_r) begin
      // entry read last cycle lands one rank further on
      r2i_we    = 1'b1;
      r2i_waddr = pdst_r;
      r2i_wdata = r2i_rd_r;
      i2r_we    = 1'b1;
      i2r_waddr = rank_t'(r2i_rd_r - 1'b1);
      i2r_wdata = pdst_r;
    end else if (state_r == S_MOVE && cur_r == end_r) begin
      // final placement of the moved id
      r2i_we    = 1'b1;
      r2i_waddr = end_r;
      r2i_wdata = tgt_r;
      i2r_we    = 1'b1;
      i2r_waddr = rank_t'(tgt_r - 1'b1);
      i2r_wdata = end_r;
    end else if (state_r == S_CHK && op_r == OP_APPEND && app_ok) begin
      r2i_we    = 1'b1;
      r2i_waddr = rank_t'(fill_r);
      r2i_wdata = tgt_r;
      i2r_we    = 1'b1;
      i2r_waddr = rank_t'(tgt_r - 1'b1);
      i2r_wdata = rank_t'(fill_r);
    end
  end

  always_ff @(posedge clk) begin
    if (r2i_we) begin
      r2i_mem[r2i_waddr] <= r2i_wdata;
    end
    r2i_rd_r <= r2i_mem[r2i_raddr];
  end

  always_ff @(posedge clk) begin
    if (i2r_we) begin
      i2r_mem[i2r_waddr] <= i2r_wdata;
    end
    i2r_rd_r <= i2r_mem[i2r_raddr];
  end

  // ---- sequencer ----
  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    tgt_nxt   = tgt_r;
    off_nxt   = off_r;
    rank_nxt  = rank_r;
    rok_nxt   = rok_r;
    cur_nxt   = cur_r;
    end_nxt   = end_r;
    up_nxt    = up_r;
    pend_nxt  = 1'b0;
    pdst_nxt  = pdst_r;
    fill_nxt  = fill_r;
    res_nxt   = res_r;
    ans_nxt   = ans_r;
    oval_nxt  = oval_r && !out_rsp.ready;

    case (state_r)
      S_IDLE: begin
        if (in_req.valid) begin
          op_nxt    = in_req.opcode;
          tgt_nxt   = in_req.target;
          off_nxt   = in_req.offset;
          state_nxt = S_RDR;
        end
      end
      S_RDR: begin
        rank_nxt  = i2r_rd_r;
        rok_nxt   = ({1'b0, i2r_rd_r} < fill_r);
        state_nxt = S_CHK;
      end
      S_CHK: begin
        state_nxt = S_IDLE;
        cur_nxt   = rank_r;
        case (op_r)
          OP_APPEND: begin
            if (app_ok) begin
              fill_nxt = count_t'(fill_r + 1'b1);
            end
          end
          OP_TOP: begin
            if (present) begin
              end_nxt   = '0;
              up_nxt    = 1'b1;
              state_nxt = S_MOVE;
            end
          end
          OP_BOTTOM: begin
            if (present) begin
              end_nxt   = rank_t'(fill_r - 1'b1);
              up_nxt    = 1'b0;
              state_nxt = S_MOVE;
            end
          end
          OP_SHIFT: begin
            if (off_r != '0 && present) begin
              if (off_r[OFF_W-1]) begin
                // upward swap, none at rank 0
                if (rank_r != '0) begin
                  end_nxt   = rank_t'(rank_r - 1'b1);
                  up_nxt    = 1'b1;
                  state_nxt = S_MOVE;
                end
              end else if (count_t'({1'b0, rank_r} + 1'b1) < fill_r) begin
                end_nxt   = rank_t'(rank_r + 1'b1);
                up_nxt    = 1'b0;
                state_nxt = S_MOVE;
              end
            end
          end
          OP_ASK: begin
            res_nxt   = present ? ID_W'(rank_r) : '0;
            state_nxt = S_OUT;
          end
          OP_QUERY: begin
            res_nxt   = qry_ok ? r2i_rd_r : '0;
            state_nxt = S_OUT;
          end
          default: begin
            state_nxt = S_IDLE;
          end
        endcase
      end
      S_MOVE: begin
        if (cur_r != end_r) begin
          // read neighbour now, write it one rank on next cycle
          pend_nxt = 1'b1;
          pdst_nxt = cur_r;
          cur_nxt  = src;
        end else if (!pend_r) begin
          state_nxt = S_IDLE;
        end
      end
      S_OUT: begin
        if (!oval_r || out_rsp.ready) begin
          ans_nxt   = res_r;
          oval_nxt  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      pend_r  <= 1'b0;
      fill_r  <= '0;
      oval_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= pend_nxt;
      fill_r  <= fill_nxt;
      oval_r  <= oval_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r   <= op_nxt;
    tgt_r  <= tgt_nxt;
    off_r  <= off_nxt;
    rank_r <= rank_nxt;
    rok_r  <= rok_nxt;
    cur_r  <= cur_nxt;
    end_r  <= end_nxt;
    up_r   <= up_nxt;
    pdst_r <= pdst_nxt;
    res_r  <= res_nxt;
    ans_r  <= ans_nxt;
  end

endmodule

`default_nettype wire
